// ===== rtl/core/mtq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mtq_pkg;

    // Vote buffer size limit
    localparam int VOTE_MAX_DEF = 8;

    // Configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_DEPTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME     = 2'd2;

    localparam int DEPTH_CFG_W = 4;

    localparam logic [DEPTH_CFG_W-1:0] FILTER_DEPTH_RST  = 4'd3;
    localparam logic [31:0]            DEBOUNCE_TIME_RST = 32'd50;
    localparam logic [31:0]            HOLD_TIME_RST     = 32'd2000;

    // Encoded mode as seen on the result channel
    localparam logic [1:0] MODE_CODE_IDLE      = 2'd0;
    localparam logic [1:0] MODE_CODE_TRIGGERED = 2'd1;
    localparam logic [1:0] MODE_CODE_ACTIVE    = 2'd2;
    localparam logic [1:0] MODE_CODE_HOLDING   = 2'd3;

    // Hold machine states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE      = 4'b0001,
        ST_TRIGGERED = 4'b0010,
        ST_ACTIVE    = 4'b0100,
        ST_HOLDING   = 4'b1000
    } mode_state_t;

    // Status from the hold machine for one item
    typedef struct packed {
        logic [1:0]  mode;
        logic        motion_detected;
        logic        triggered_event;
        logic        active_event;
        logic        idle_event;
        logic        stable_level;
        logic [31:0] trigger_total;
        logic [31:0] last_duration;
    } fsm_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/mtq_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mtq_in_if;
    logic        valid;
    logic        ready;
    logic        sensor_level;
    logic [31:0] now_time;

    modport source (output valid, output sensor_level, output now_time, input ready);
    modport sink   (input valid, input sensor_level, input now_time, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mtq_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mtq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic        motion_detected;
    logic        triggered_event;
    logic        active_event;
    logic        idle_event;
    logic        filtered_level;
    logic        stable_level;
    logic [31:0] trigger_total;
    logic [31:0] last_duration;

    modport source (
        output valid, output mode, output motion_detected, output triggered_event,
        output active_event, output idle_event, output filtered_level,
        output stable_level, output trigger_total, output last_duration,
        input ready
    );
    modport sink (
        input valid, input mode, input motion_detected, input triggered_event,
        input active_event, input idle_event, input filtered_level,
        input stable_level, input trigger_total, input last_duration,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/mtq_vote.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Circular sample buffer with majority vote over the first depth entries.
module mtq_vote #(
    parameter int VOTE_MAX = mtq_pkg::VOTE_MAX_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           advance,
    input  wire logic                           level,
    input  wire logic [mtq_pkg::DEPTH_CFG_W-1:0] depth_cfg,
    output logic                                filtered
);

    localparam int PW = (VOTE_MAX > 1) ? $clog2(VOTE_MAX) : 1;
    localparam int DW = $clog2(VOTE_MAX + 1);

    logic [VOTE_MAX-1:0] samples_reg, samples_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [DW-1:0]       depth;
    logic [DW-1:0]       wrap_val;
    logic [DW-1:0]       ones;

    // Clamp depth to 1..VOTE_MAX
    always_comb
    begin
        if (depth_cfg == '0)
            depth = DW'(1);
        else if (depth_cfg > mtq_pkg::DEPTH_CFG_W'(VOTE_MAX))
            depth = DW'(VOTE_MAX);
        else
            depth = DW'(depth_cfg);
    end

    always_comb
    begin
        samples_next          = samples_reg;
        samples_next[pos_reg] = level;

        // (pos + 1) mod depth; the sum never exceeds VOTE_MAX
        wrap_val = DW'(pos_reg) + DW'(1);
        for (int i = 0; i < VOTE_MAX; i++)
        begin
            if (wrap_val >= depth)
                wrap_val = wrap_val - depth;
        end
        pos_next = wrap_val[PW-1:0];

        ones = '0;
        for (int i = 0; i < VOTE_MAX; i++)
        begin
            if (samples_next[i] && (DW'(i) < depth))
                ones = ones + DW'(1);
        end
    end

    assign filtered = (ones > (depth >> 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_reg <= '0;
            pos_reg     <= '0;
        end
        else if (advance)
        begin
            samples_reg <= samples_next;
            pos_reg     <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mtq_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Debounce timer and the idle/triggered/active/holding machine.
module mtq_fsm (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire logic                 filtered,
    input  wire logic [31:0]          now,
    input  wire logic [31:0]          debounce_time,
    input  wire logic [31:0]          hold_time,
    output mtq_pkg::fsm_status_t      status
);

    mtq_pkg::mode_state_t state_reg, state_next;

    logic        stable_reg, stable_next;
    logic [31:0] change_ts_reg, change_ts_next;
    logic [31:0] trig_ts_reg, trig_ts_next;
    logic [31:0] hold_ts_reg, hold_ts_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] dur_reg, dur_next;
    logic        ev_trig, ev_act, ev_idle;
    logic [1:0]  mode_code;

    // Debounce: accept a change only once it has persisted
    always_comb
    begin
        stable_next    = stable_reg;
        change_ts_next = change_ts_reg;
        if (filtered != stable_reg)
        begin
            if ((now - change_ts_reg) >= debounce_time)
            begin
                stable_next    = filtered;
                change_ts_next = now;
            end
        end
        else
        begin
            change_ts_next = now;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        trig_ts_next = trig_ts_reg;
        hold_ts_next = hold_ts_reg;
        count_next   = count_reg;
        dur_next     = dur_reg;
        ev_trig      = 1'b0;
        ev_act       = 1'b0;
        ev_idle      = 1'b0;
        unique case (state_reg)
            mtq_pkg::ST_IDLE:
            begin
                if (stable_next)
                begin
                    state_next   = mtq_pkg::ST_TRIGGERED;
                    trig_ts_next = now;
                    count_next   = count_reg + 32'd1;
                    ev_trig      = 1'b1;
                end
            end
            mtq_pkg::ST_TRIGGERED:
            begin
                state_next = mtq_pkg::ST_ACTIVE;
                ev_act     = 1'b1;
            end
            mtq_pkg::ST_ACTIVE:
            begin
                if (stable_next)
                    ev_act = 1'b1;
                else
                begin
                    state_next   = mtq_pkg::ST_HOLDING;
                    hold_ts_next = now;
                    dur_next     = now - trig_ts_reg;
                end
            end
            mtq_pkg::ST_HOLDING:
            begin
                if (stable_next)
                begin
                    // retrigger keeps the original trigger time
                    state_next = mtq_pkg::ST_ACTIVE;
                    count_next = count_reg + 32'd1;
                    ev_trig    = 1'b1;
                end
                else if ((now - hold_ts_reg) >= hold_time)
                begin
                    state_next = mtq_pkg::ST_IDLE;
                    ev_idle    = 1'b1;
                end
                else
                    ev_act = 1'b1;
            end
            default:
            begin
                state_next = mtq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        unique case (state_next)
            mtq_pkg::ST_IDLE:      mode_code = mtq_pkg::MODE_CODE_IDLE;
            mtq_pkg::ST_TRIGGERED: mode_code = mtq_pkg::MODE_CODE_TRIGGERED;
            mtq_pkg::ST_ACTIVE:    mode_code = mtq_pkg::MODE_CODE_ACTIVE;
            mtq_pkg::ST_HOLDING:   mode_code = mtq_pkg::MODE_CODE_HOLDING;
            default:               mode_code = mtq_pkg::MODE_CODE_IDLE;
        endcase
    end

    always_comb
    begin
        status.mode            = mode_code;
        status.motion_detected = (mode_code != mtq_pkg::MODE_CODE_IDLE);
        status.triggered_event = ev_trig;
        status.active_event    = ev_act;
        status.idle_event      = ev_idle;
        status.stable_level    = stable_next;
        status.trigger_total   = count_next;
        status.last_duration   = dur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mtq_pkg::ST_IDLE;
            stable_reg    <= 1'b0;
            change_ts_reg <= '0;
            trig_ts_reg   <= '0;
            hold_ts_reg   <= '0;
            count_reg     <= '0;
            dur_reg       <= '0;
        end
        else if (advance)
        begin
            state_reg     <= state_next;
            stable_reg    <= stable_next;
            change_ts_reg <= change_ts_next;
            trig_ts_reg   <= trig_ts_next;
            hold_ts_reg   <= hold_ts_next;
            count_reg     <= count_next;
            dur_reg       <= dur_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/motion_sensor_qualifier.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Motion sensor qualifier: majority vote, debounce, hold machine.
// Path: an accepted item is held in the input register; the combinational
// vote and mode update feed the result register, which drives the results.
// Throughput: 1 item per cycle while the result side is not stalled.
// Reset (rst_n, async low): vote buffer, debounce and mode state cleared,
// config returns to depth 3, debounce 50 ms, hold 2000 ms.
module motion_sensor_qualifier #(
    parameter int VOTE_MAX = mtq_pkg::VOTE_MAX_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    mtq_in_if.sink                             samples,
    mtq_out_if.source                          results,
    input  wire logic                          wr_en,
    input  wire logic [mtq_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [mtq_pkg::CFG_DATA_W-1:0] wr_data
);

    // ---------------- configuration registers ----------------
    logic [mtq_pkg::DEPTH_CFG_W-1:0] depth_cfg_reg;
    logic [31:0]                     debounce_reg;
    logic [31:0]                     hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_cfg_reg <= mtq_pkg::FILTER_DEPTH_RST;
            debounce_reg  <= mtq_pkg::DEBOUNCE_TIME_RST;
            hold_reg      <= mtq_pkg::HOLD_TIME_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                mtq_pkg::REG_FILTER_DEPTH:  depth_cfg_reg <= wr_data[mtq_pkg::DEPTH_CFG_W-1:0];
                mtq_pkg::REG_DEBOUNCE_TIME: debounce_reg  <= wr_data[31:0];
                mtq_pkg::REG_HOLD_TIME:     hold_reg      <= wr_data[31:0];
                default:                    ;  // unmapped index, ignored
            endcase
        end
    end

    // ---------------- input register ----------------
    logic        in_valid_reg;
    logic        level_reg;
    logic [31:0] now_reg;
    logic        advance;
    logic        accept;

    // The item in the input register moves on whenever the result register
    // is empty or being drained this cycle.
    assign advance       = in_valid_reg && (!results.valid || results.ready);
    assign samples.ready = !in_valid_reg || advance;
    assign accept        = samples.valid && samples.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            level_reg <= samples.sensor_level;
            now_reg   <= samples.now_time;
        end
    end

    // ---------------- processing ----------------
    logic                 filtered;
    mtq_pkg::fsm_status_t status;

    mtq_vote #(
        .VOTE_MAX (VOTE_MAX)
    ) u_vote (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .level     (level_reg),
        .depth_cfg (depth_cfg_reg),
        .filtered  (filtered)
    );

    mtq_fsm u_fsm (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .filtered      (filtered),
        .now           (now_reg),
        .debounce_time (debounce_reg),
        .hold_time     (hold_reg),
        .status        (status)
    );

    // ---------------- result register ----------------
    logic                 out_valid_reg;
    logic                 filtered_reg;
    mtq_pkg::fsm_status_t status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            filtered_reg <= filtered;
            status_reg   <= status;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.mode            = status_reg.mode;
    assign results.motion_detected = status_reg.motion_detected;
    assign results.triggered_event = status_reg.triggered_event;
    assign results.active_event    = status_reg.active_event;
    assign results.idle_event      = status_reg.idle_event;
    assign results.filtered_level  = filtered_reg;
    assign results.stable_level    = status_reg.stable_level;
    assign results.trigger_total   = status_reg.trigger_total;
    assign results.last_duration   = status_reg.last_duration;

endmodule

`default_nettype wire
